/* design/erp_pkg.sv */
// Package for the Euclidean rhythm pattern block: field widths, default sizes,
// configuration register indexes and their reset values.
// Has no dependencies; every design file but erp_queue refers to it by scoped names.
package erp_pkg;

	// Default sizes handed to the top-level parameters
	localparam int PATTERN_SLOTS_DEF = 256;
	localparam int MAX_COUNT_DEF     = 64;

	// Fixed field widths
	localparam int COUNT_W     = 7;
	localparam int ROTATE_W    = 4;
	localparam int INDEX_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	// Depth of the queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

	// Register reset values
	localparam logic [COUNT_W-1:0]         REST_COUNT_RST    = 7'd12;
	localparam logic [COUNT_W-1:0]         HIT_COUNT_RST     = 7'd4;
	localparam logic signed [ROTATE_W-1:0] ROTATE_AMOUNT_RST = 4'sd0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REST_COUNT    = 2'd0,
		CFG_HIT_COUNT     = 2'd1,
		CFG_ROTATE_AMOUNT = 2'd2
	} cfg_reg_t;

endpackage

/* design/erp_queue.sv */
// Short first-in first-out queue of slot numbers between the front and the back.
// Depends on nothing beyond its parameters.
module erp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/erp_front.sv */
// Front of the Euclidean rhythm pattern block: takes a step word, adds the
// rotation and reduces the result into the slot range, then hands it on.
// Depends on erp_pkg.
module erp_front #(
	parameter int PATTERN_SLOTS = erp_pkg::PATTERN_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                hold,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [erp_pkg::INDEX_W-1:0]         step_index,
	input  logic signed [erp_pkg::ROTATE_W-1:0] rotate_amount,
	output logic                                q_valid,
	input  logic                                q_ready,
	output logic [$clog2(PATTERN_SLOTS)-1:0]    q_data
);

	localparam int SLOT_W = $clog2(PATTERN_SLOTS);
	localparam int VAL_W  = ((SLOT_W > erp_pkg::INDEX_W) ? SLOT_W : erp_pkg::INDEX_W) + 1;
	localparam logic [VAL_W-1:0] SLOTS_V = VAL_W'(PATTERN_SLOTS);

	logic             busy_q;
	logic [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] rot_se;
	logic [VAL_W-1:0] rot_u;
	logic [VAL_W-1:0] start_val;
	logic             in_range;
	logic             accept;

	// A negative rotation becomes its positive equivalent modulo the slot count.
	assign rot_se    = VAL_W'(rotate_amount);
	assign rot_u     = rot_se;
	assign start_val = VAL_W'(step_index)
		+ (rotate_amount[erp_pkg::ROTATE_W-1] ? SLOTS_V + rot_u : rot_u);

	assign in_range = (val_q < SLOTS_V);
	assign in_ready = !busy_q && !hold;
	assign accept   = in_valid && in_ready;
	assign q_valid  = busy_q && in_range;
	assign q_data   = val_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (busy_q && in_range && q_ready) begin
			busy_q <= 1'b0;
		end
	end

	// One subtraction of the slot count per cycle until the value is in range.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= start_val;
		end else if (busy_q && !in_range) begin
			val_q <= val_q - SLOTS_V;
		end
	end

endmodule

/* design/erp_builder.sv */
// Pattern builder: sweeps every slot once after reset or a register write and
// writes the onset bit of the rhythm for that slot into the back's pattern store.
// Depends on erp_pkg.
module erp_builder #(
	parameter int PATTERN_SLOTS = erp_pkg::PATTERN_SLOTS_DEF,
	parameter int MAX_COUNT     = erp_pkg::MAX_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [erp_pkg::COUNT_W-1:0]         rest_count,
	input  logic [erp_pkg::COUNT_W-1:0]         hit_count,
	output logic                                busy,
	output logic                                wr_en,
	output logic [$clog2(PATTERN_SLOTS)-1:0]    wr_addr,
	output logic                                wr_bit
);

	localparam int SLOT_W = $clog2(PATTERN_SLOTS);
	localparam int CNT_W  = $clog2(MAX_COUNT + 1);
	localparam int ACC_W  = 2 * CNT_W;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_FILL = 2'b10
	} build_state_t;

	build_state_t      state_q;
	logic [SLOT_W-1:0] slot_q;
	logic              start_q;
	logic [ACC_W-1:0]  a_q;
	logic [ACC_W-1:0]  b_q;

	logic [CNT_W-1:0]  rests;
	logic [CNT_W-1:0]  hits_sat;
	logic [CNT_W-1:0]  hits;
	logic              empty;
	logic              letter;
	logic              start_d;
	logic [ACC_W-1:0]  a_d;
	logic [ACC_W-1:0]  b_d;

	always_comb begin
		rests    = (int'(rest_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT) : CNT_W'(rest_count);
		hits_sat = (int'(hit_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT) : CNT_W'(hit_count);
		hits     = (hits_sat > rests) ? rests : hits_sat;
	end

	assign empty = (hits == '0) || (rests == '0)
		|| (int'(slot_q) >= int'(rests) + int'(hits));

	// The accumulators run on the unreduced counts: the comparisons are the same,
	// and they meet exactly at the last letter of each period, which is a rest.
	always_comb begin
		letter  = 1'b0;
		start_d = start_q;
		a_d     = a_q;
		b_d     = b_q;
		if (empty) begin
			letter = 1'b0;
		end else if (start_q) begin
			letter  = 1'b1;
			a_d     = ACC_W'(hits);
			b_d     = ACC_W'(rests);
			start_d = 1'b0;
		end else if (a_q == b_q) begin
			letter  = 1'b0;
			start_d = 1'b1;
		end else if (a_q > b_q) begin
			letter = 1'b1;
			b_d    = b_q + ACC_W'(rests);
		end else begin
			letter = 1'b0;
			a_d    = a_q + ACC_W'(hits);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_FILL;
			slot_q  <= '0;
			start_q <= 1'b1;
		end else if (restart) begin
			state_q <= B_FILL;
			slot_q  <= '0;
			start_q <= 1'b1;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					state_q <= B_IDLE;
				end
				B_FILL: begin
					start_q <= start_d;
					if (slot_q == SLOT_W'(PATTERN_SLOTS - 1)) begin
						state_q <= B_IDLE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_FILL) begin
			a_q <= a_d;
			b_q <= b_d;
		end
	end

	assign busy    = (state_q == B_FILL);
	assign wr_en   = (state_q == B_FILL) && !restart;
	assign wr_addr = slot_q;
	assign wr_bit  = letter;

endmodule

/* design/erp_back.sv */
// Back of the Euclidean rhythm pattern block: holds the pattern store, looks up
// each queued slot and presents the onset bit through an output register.
// Depends on erp_pkg only through its parameter default.
module erp_back #(
	parameter int PATTERN_SLOTS = erp_pkg::PATTERN_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [$clog2(PATTERN_SLOTS)-1:0] wr_addr,
	input  logic                             wr_bit,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  logic [$clog2(PATTERN_SLOTS)-1:0] q_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit
);

	logic pattern_q [PATTERN_SLOTS];
	logic hit_s1;
	logic valid_s1;
	logic out_valid_q;
	logic hit_q;
	logic s1_advance;
	logic pop;

	assign s1_advance = valid_s1 && (!out_valid_q || out_ready);
	assign pop        = q_valid && (!valid_s1 || s1_advance);
	assign q_ready    = !valid_s1 || s1_advance;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pattern_q[wr_addr] <= wr_bit;
		end
		if (pop) begin
			hit_s1 <= pattern_q[q_data];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
			if (s1_advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			hit_q <= hit_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

endmodule

/* design/euclidean_rhythm_pattern.sv */
// Top level of the Euclidean rhythm pattern block: configuration registers,
// front, queue, pattern builder and back. Depends on erp_pkg and all erp_ modules.
//
//   channel   signals                          word
//   config    cfg_write, cfg_index, cfg_data   one register write, no handshake
//   input     in_valid / in_ready              step_index
//   output    out_valid / out_ready            hit
//
// After reset, and after every register write, the builder writes every slot of the
// pattern store; in_ready stays low for that sweep. A word is registered in the
// front, reduced there by repeated subtraction of PATTERN_SLOTS, then passes the
// queue and the back's lookup and output registers. The front, queue and back stall
// independently; the back issues one store read a cycle unless out_ready holds it.
module euclidean_rhythm_pattern #(
	parameter int PATTERN_SLOTS = erp_pkg::PATTERN_SLOTS_DEF,
	parameter int MAX_COUNT     = erp_pkg::MAX_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [erp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [erp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [erp_pkg::INDEX_W-1:0]       step_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit
);

	localparam int SLOT_W = $clog2(PATTERN_SLOTS);

	logic [erp_pkg::COUNT_W-1:0]         rest_count_q;
	logic [erp_pkg::COUNT_W-1:0]         hit_count_q;
	logic signed [erp_pkg::ROTATE_W-1:0] rotate_amount_q;

	logic              build_busy;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic              wr_bit;
	logic              front_valid;
	logic              front_ready;
	logic [SLOT_W-1:0] front_slot;
	logic              back_valid;
	logic              back_ready;
	logic [SLOT_W-1:0] back_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_count_q    <= erp_pkg::REST_COUNT_RST;
			hit_count_q     <= erp_pkg::HIT_COUNT_RST;
			rotate_amount_q <= erp_pkg::ROTATE_AMOUNT_RST;
		end else if (cfg_write) begin
			unique case (erp_pkg::cfg_reg_t'(cfg_index))
				erp_pkg::CFG_REST_COUNT: begin
					rest_count_q <= cfg_data[erp_pkg::COUNT_W-1:0];
				end
				erp_pkg::CFG_HIT_COUNT: begin
					hit_count_q <= cfg_data[erp_pkg::COUNT_W-1:0];
				end
				erp_pkg::CFG_ROTATE_AMOUNT: begin
					rotate_amount_q <= signed'(cfg_data[erp_pkg::ROTATE_W-1:0]);
				end
				default: begin
					rest_count_q <= rest_count_q;
				end
			endcase
		end
	end

	erp_builder #(
		.PATTERN_SLOTS(PATTERN_SLOTS),
		.MAX_COUNT    (MAX_COUNT)
	) u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_write),
		.rest_count(rest_count_q),
		.hit_count (hit_count_q),
		.busy      (build_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_bit    (wr_bit)
	);

	erp_front #(
		.PATTERN_SLOTS(PATTERN_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (build_busy),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.step_index   (step_index),
		.rotate_amount(rotate_amount_q),
		.q_valid      (front_valid),
		.q_ready      (front_ready),
		.q_data       (front_slot)
	);

	erp_queue #(
		.WIDTH(SLOT_W),
		.DEPTH(erp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_data (front_slot),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_data  (back_slot)
	);

	erp_back #(
		.PATTERN_SLOTS(PATTERN_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_bit   (wr_bit),
		.q_valid  (back_valid),
		.q_ready  (back_ready),
		.q_data   (back_slot),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit)
	);

`ifndef SYNTHESIS
	// No word may enter while the pattern store is being rebuilt.
	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		build_busy |-> !in_ready)
		else $error("input accepted during pattern build");

	// A register write always starts a fresh sweep of the store.
	a_write_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> build_busy)
		else $error("register write did not restart the pattern build");

	// Checks that the store is not written while a lookup is queued for the back.
	a_no_write_with_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !back_valid)
		else $error("pattern store written while a lookup is pending");
`endif

endmodule
